// ===== hdl/mbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg: shared definitions of the modular binomial engine
// Holds the prime modulus, the Barrett constant and the operation and status
// codes.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned VAL_W = 30;

  localparam logic [VAL_W-1:0] PRIME_MOD = 30'd1000000007;
  // Fermat exponent for the modular inverse.
  localparam logic [VAL_W-1:0] INV_EXP = 30'd1000000005;
  // floor(2^60 / PRIME_MOD), fits in 31 bits.
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  typedef enum logic [2:0] {
    FN_BUILD = 3'd0,
    FN_BINOM = 3'd1,
    FN_PERM  = 3'd2,
    FN_SBPOS = 3'd3,
    FN_SBNN  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_BEYOND    = 2'd2
  } status_e;

endpackage : mbe_pkg
`default_nettype wire

// ===== hdl/modular_binomial_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_binomial_engine: factorial tables and counts modulo 1000000007
// Builds factorial and inverse factorial tables and answers binomial,
// permutation and stars-and-bars queries from them.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: func; tdata: query_n[11:0], query_k[24:12]
//  m_axis    out        tuser: status; tdata: value[29:0]
//  cfg       in         table_top[11:0], written when cfg_we_i is high
//
//  A query reads both tables and then makes two dependent passes through the
//  four-stage modular multiplier. A permutation needs one pass; a rejected
//  query goes straight to its result. A build makes one multiplier pass per
//  table entry in each table plus the square-and-multiply for the top inverse.
//  The block takes one item at a time; tready is high only while idle. A
//  result waits in the output register while the next item is accepted.
//  Reset clears built state; table memories are not cleared.
// ----------------------------------------------------------------------------
module modular_binomial_engine #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [2:0]  s_axis_tuser_i,  // func[2:0]
  input  wire logic [31:0] s_axis_tdata_i,  // query_n[11:0], query_k[24:12]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [1:0]       m_axis_tuser_o,  // status[1:0]
  output logic [31:0]      m_axis_tdata_o   // value[29:0]
);
  import mbe_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TW = (AW > 12) ? AW : 12;
  localparam int unsigned SW = ((AW > 14) ? AW : 14) + 2;
  localparam logic [TW-1:0] TOP_MAX = TW'(TABLE_DEPTH - 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_BFACT  = 14'b00000000000010,
    S_BFWAIT = 14'b00000000000100,
    S_BPOW   = 14'b00000000001000,
    S_PWA    = 14'b00000000010000,
    S_PWB    = 14'b00000000100000,
    S_BINV   = 14'b00000001000000,
    S_BIWAIT = 14'b00000010000000,
    S_Q0     = 14'b00000100000000,
    S_Q1     = 14'b00001000000000,
    S_Q2     = 14'b00010000000000,
    S_QW1    = 14'b00100000000000,
    S_QW2    = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [11:0]      table_top_q;
  logic [AW-1:0]    built_top_q, top_q;
  logic             ready_q;
  logic [AW:0]      i_q;
  logic [VAL_W-1:0] run_q, acc_q, base_q, kinv_q;
  logic [VAL_W-1:0] exp_q;
  logic [AW-1:0]    nn_q, nk_q, kk_q;
  logic             perm_q;
  logic [VAL_W-1:0] res_val_q;
  logic [1:0]       res_st_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_val_q;
  logic [1:0]       out_st_q;

  logic             accept;
  logic             mul_in_vld, mul_out_vld;
  logic [VAL_W-1:0] mul_a, mul_b, mul_res;
  logic             f_we, i_we;
  logic [AW-1:0]    f_waddr, i_waddr, i_raddr;
  logic [VAL_W-1:0] f_wdata, i_wdata, f_rdata, i_rdata;
  logic             out_free;

  // Query operand decode.
  logic signed [SW-1:0] n_s, k_s, nn_s, kk_s, bt_s;
  logic                 q_bad, q_beyond;
  logic [TW-1:0]        tt_ext;
  logic [AW-1:0]        top_new;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    n_s  = SW'(s_axis_tdata_i[11:0]);
    k_s  = SW'(signed'(s_axis_tdata_i[24:12]));
    bt_s = SW'(built_top_q);
    nn_s = n_s;
    kk_s = k_s;
    q_bad = 1'b0;
    case (s_axis_tuser_i)
      FN_SBPOS: begin
        nn_s  = n_s - SW'(1);
        kk_s  = k_s - SW'(1);
        q_bad = (n_s < k_s);
      end
      FN_SBNN: begin
        nn_s = n_s + k_s - SW'(1);
        kk_s = k_s - SW'(1);
      end
      default: begin
      end
    endcase
    q_bad    = q_bad || (kk_s < 0) || (kk_s > nn_s);
    q_beyond = (nn_s > bt_s);
    tt_ext   = TW'(table_top_q);
    top_new  = (tt_ext > TOP_MAX) ? AW'(TOP_MAX) : AW'(tt_ext);
  end

  // Shared multiplier issue and table write selection.
  always_comb begin
    mul_in_vld = 1'b0;
    mul_a      = run_q;
    mul_b      = VAL_W'(i_q);
    f_we       = 1'b0;
    f_waddr    = i_q[AW-1:0];
    f_wdata    = mul_res;
    i_we       = 1'b0;
    i_waddr    = AW'(i_q - 1'b1);
    i_wdata    = mul_res;
    case (state_q)
      S_IDLE: begin
        if (accept && s_axis_tuser_i == FN_BUILD) begin
          f_we    = 1'b1;
          f_waddr = '0;
          f_wdata = VAL_W'(1);
        end
      end
      S_BFACT: mul_in_vld = (i_q <= {1'b0, top_q});
      S_BFWAIT: f_we = mul_out_vld;
      S_BPOW: begin
        if (exp_q == '0) begin
          i_we    = 1'b1;
          i_waddr = top_q;
          i_wdata = acc_q;
        end else begin
          mul_in_vld = 1'b1;
          mul_a      = exp_q[0] ? acc_q : base_q;
          mul_b      = base_q;
        end
      end
      S_PWA: begin
        mul_in_vld = mul_out_vld;
        mul_a      = base_q;
        mul_b      = base_q;
      end
      S_BINV: mul_in_vld = (i_q != '0);
      S_BIWAIT: i_we = mul_out_vld;
      S_Q1: begin
        mul_in_vld = 1'b1;
        mul_a      = f_rdata;
        mul_b      = i_rdata;
      end
      S_QW1: begin
        mul_in_vld = mul_out_vld && !perm_q;
        mul_a      = mul_res;
        mul_b      = kinv_q;
      end
      default: begin
      end
    endcase
  end

  assign i_raddr = (state_q == S_Q0) ? nk_q : kk_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == FN_BUILD) begin
            state_d = S_BFACT;
          end else if (s_axis_tuser_i inside {FN_BINOM, FN_PERM, FN_SBPOS, FN_SBNN}
                       && ready_q && !q_bad && !q_beyond) begin
            state_d = S_Q0;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_BFACT:  state_d = (i_q <= {1'b0, top_q}) ? S_BFWAIT : S_BPOW;
      S_BFWAIT: if (mul_out_vld) state_d = S_BFACT;
      S_BPOW: begin
        if (exp_q == '0) begin
          state_d = S_BINV;
        end else begin
          state_d = exp_q[0] ? S_PWA : S_PWB;
        end
      end
      S_PWA:    if (mul_out_vld) state_d = S_PWB;
      S_PWB:    if (mul_out_vld) state_d = S_BPOW;
      S_BINV:   state_d = (i_q != '0) ? S_BIWAIT : S_FIN;
      S_BIWAIT: if (mul_out_vld) state_d = S_BINV;
      S_Q0:     state_d = S_Q1;
      S_Q1:     state_d = S_Q2;
      S_Q2:     state_d = S_QW1;
      S_QW1:    if (mul_out_vld) state_d = perm_q ? S_FIN : S_QW2;
      S_QW2:    if (mul_out_vld) state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      table_top_q <= 12'd4095;
      built_top_q <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        table_top_q <= cfg_wdata_i;
      end
      if (state_q == S_BINV && i_q == '0) begin
        built_top_q <= top_q;
        ready_q     <= 1'b1;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        res_val_q <= '0;
        res_st_q  <= ST_OK;
        nn_q      <= AW'(nn_s);
        nk_q      <= AW'(nn_s - kk_s);
        kk_q      <= AW'(kk_s);
        perm_q    <= (s_axis_tuser_i == FN_PERM);
        run_q     <= VAL_W'(1);
        i_q       <= (AW+1)'(1);
        top_q     <= top_new;
        if (s_axis_tuser_i inside {FN_BINOM, FN_PERM, FN_SBPOS, FN_SBNN}) begin
          if (!ready_q) begin
            res_st_q <= ST_NOT_BUILT;
          end else if (!q_bad && q_beyond) begin
            res_st_q <= ST_BEYOND;
          end
        end
      end
      S_BFACT: begin
        if (i_q > {1'b0, top_q}) begin
          base_q <= run_q;
          acc_q  <= VAL_W'(1);
          exp_q  <= INV_EXP;
        end
      end
      S_BFWAIT: begin
        if (mul_out_vld) begin
          run_q <= mul_res;
          i_q   <= i_q + 1'b1;
        end
      end
      S_BPOW: begin
        if (exp_q == '0) begin
          run_q <= acc_q;
          i_q   <= {1'b0, top_q};
        end
      end
      S_PWA: if (mul_out_vld) acc_q <= mul_res;
      S_PWB: begin
        if (mul_out_vld) begin
          base_q <= mul_res;
          exp_q  <= exp_q >> 1;
        end
      end
      S_BIWAIT: begin
        if (mul_out_vld) begin
          run_q <= mul_res;
          i_q   <= i_q - 1'b1;
        end
      end
      S_Q2:  kinv_q <= i_rdata;
      S_QW1: if (mul_out_vld) res_val_q <= mul_res;
      S_QW2: if (mul_out_vld) res_val_q <= mul_res;
      S_FIN: begin
        if (out_free) begin
          out_val_q <= res_val_q;
          out_st_q  <= res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

  mbe_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_in_vld),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .valid_o (mul_out_vld),
    .res_o   (mul_res)
  );

  mbe_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_fact (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (nn_q),
    .rdata_o (f_rdata)
  );

  mbe_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_inv (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (i_wdata),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_val_q};
  assign m_axis_tuser_o  = out_st_q;

endmodule : modular_binomial_engine
`default_nettype wire

// ===== hdl/mbe_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_mulmod: pipelined modular multiplier
// Computes a*b mod PRIME_MOD with a four-stage Barrett reduction; one item may
// enter every cycle.
// ----------------------------------------------------------------------------
module mbe_mulmod (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [mbe_pkg::VAL_W-1:0]  a_i,
  input  wire logic [mbe_pkg::VAL_W-1:0]  b_i,
  output logic                            valid_o,
  output logic [mbe_pkg::VAL_W-1:0]       res_o
);
  import mbe_pkg::*;

  logic [3:0]        vld_q;
  logic [59:0]       p_q;
  logic [61:0]       q2_q;
  logic [31:0]       p2_q, p3_q, t_q;
  logic [VAL_W-1:0]  res_q;
  logic [31:0]       r;
  logic [31:0]       mod32, mod2x;

  assign mod32 = 32'(PRIME_MOD);
  assign mod2x = 32'(PRIME_MOD) << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // The remainder estimate stays below three times the modulus.
  assign r = p3_q - t_q;

  always_ff @(posedge clk_i) begin
    p_q  <= 60'(a_i) * 60'(b_i);
    q2_q <= 62'(p_q[59:29]) * 62'(BARRETT_MU);
    p2_q <= p_q[31:0];
    // Only the low 32 bits of the quotient times the modulus are needed.
    t_q  <= 32'(q2_q[61:31]) * 32'(PRIME_MOD);
    p3_q <= p2_q;
    if (r >= mod2x) begin
      res_q <= VAL_W'(r - mod2x);
    end else if (r >= mod32) begin
      res_q <= VAL_W'(r - mod32);
    end else begin
      res_q <= VAL_W'(r);
    end
  end

  assign valid_o = vld_q[3];
  assign res_o   = res_q;

endmodule : mbe_mulmod
`default_nettype wire

// ===== hdl/mbe_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_ram: table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbe_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [mbe_pkg::VAL_W-1:0]  wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic [mbe_pkg::VAL_W-1:0]       rdata_o
);
  import mbe_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule : mbe_ram
`default_nettype wire
